FILE: rtl/fss_pkg.sv
// ---------------------------------------------------------------------------
// fss_pkg: shared types and constants for the four-sum search block
// Entry layout of the item store, result record and engine states.
// ---------------------------------------------------------------------------
package fss_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 11;
  localparam int WANT_W = VAL_W + 2;

  // one stored item: value and its 1-based arrival position
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
  } entry_t;

  // search result handed from the engine to the top level
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] p1;
    logic [POS_W-1:0] p2;
    logic [POS_W-1:0] p3;
    logic [POS_W-1:0] p4;
  } result_t;

  // sort / search engine states
  typedef enum logic [3:0] {
    E_IDLE,
    E_SORT_KEY,
    E_SORT_KEYW,
    E_SORT_CMP,
    E_SORT_PUT,
    E_PAIR_RD,
    E_PAIR_WANT,
    E_LR_RD,
    E_LR_CMP
  } eng_state_t;

  // top-level sequencing
  typedef enum logic [1:0] {
    T_LOAD,
    T_RUN,
    T_EMIT
  } top_state_t;

endpackage

FILE: rtl/fss_mem.sv
// ---------------------------------------------------------------------------
// fss_mem: item store
// One write port, two read ports, read data registered.
// ---------------------------------------------------------------------------
module fss_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   wa,
  input  fss_pkg::entry_t wd,
  input  logic [AW-1:0]   ra0,
  input  logic [AW-1:0]   ra1,
  output fss_pkg::entry_t rd0,
  output fss_pkg::entry_t rd1
);

  fss_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

FILE: rtl/fss_engine.sv
// ---------------------------------------------------------------------------
// fss_engine: in-memory sort and four-sum search
// Insertion sort over the store, then for each pair a two-pointer scan.
// ---------------------------------------------------------------------------
module fss_engine #(
  parameter int CW = 11,
  parameter int AW = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [CW-1:0]              n,
  input  logic signed [fss_pkg::VAL_W-1:0] target,
  input  fss_pkg::entry_t            rd0,
  input  fss_pkg::entry_t            rd1,
  output logic [AW-1:0]              ra0,
  output logic [AW-1:0]              ra1,
  output logic                       we,
  output logic [AW-1:0]              wa,
  output fss_pkg::entry_t            wd,
  output logic                       done,
  output fss_pkg::result_t           res
);

  fss_pkg::eng_state_t state, state_next;

  logic [CW-1:0] a, b, i, j, l, r;
  fss_pkg::entry_t key;
  logic signed [fss_pkg::WANT_W-1:0] want;
  logic [fss_pkg::POS_W-1:0] pi, pj;

  logic gt;
  logic [CW-1:0] a_p1, b_m1, b_m2, a_m1, j_p1, i_p1, lo, ro;
  logic signed [fss_pkg::WANT_W-1:0] sum_lr, want_calc;
  logic hit, more, j_more, i_more;

  // datapath helpers
  always_comb begin
    gt     = rd0.val > key.val;
    a_p1   = a + 1'b1;
    a_m1   = a - 1'b1;
    b_m1   = b - 1'b1;
    b_m2   = b - 2'd2;
    j_p1   = j + 1'b1;
    i_p1   = i + 1'b1;
    sum_lr = fss_pkg::WANT_W'(rd0.val) + fss_pkg::WANT_W'(rd1.val);
    want_calc = fss_pkg::WANT_W'(target) - fss_pkg::WANT_W'(rd0.val)
              - fss_pkg::WANT_W'(rd1.val);
    hit    = sum_lr == want;
    lo     = (sum_lr < want) ? l + 1'b1 : l;
    ro     = (sum_lr > want) ? r - 1'b1 : r;
    more   = lo < ro;
    j_more = ({1'b0, j_p1} + (CW+1)'(2)) < {1'b0, n};
    i_more = ({1'b0, i_p1} + (CW+1)'(3)) < {1'b0, n};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fss_pkg::E_IDLE:      if (start) state_next = fss_pkg::E_SORT_KEY;
      fss_pkg::E_SORT_KEY:  state_next = fss_pkg::E_SORT_KEYW;
      fss_pkg::E_SORT_KEYW: state_next = fss_pkg::E_SORT_CMP;
      fss_pkg::E_SORT_CMP: begin
        if (gt) begin
          state_next = (b_m1 == '0) ? fss_pkg::E_SORT_PUT : fss_pkg::E_SORT_CMP;
        end else begin
          state_next = (a_p1 == n) ? fss_pkg::E_PAIR_RD : fss_pkg::E_SORT_KEY;
        end
      end
      fss_pkg::E_SORT_PUT:
        state_next = (a_p1 == n) ? fss_pkg::E_PAIR_RD : fss_pkg::E_SORT_KEY;
      fss_pkg::E_PAIR_RD:   state_next = fss_pkg::E_PAIR_WANT;
      fss_pkg::E_PAIR_WANT: state_next = fss_pkg::E_LR_RD;
      fss_pkg::E_LR_RD:     state_next = fss_pkg::E_LR_CMP;
      fss_pkg::E_LR_CMP: begin
        if (hit)                  state_next = fss_pkg::E_IDLE;
        else if (more)            state_next = fss_pkg::E_LR_RD;
        else if (j_more || i_more) state_next = fss_pkg::E_PAIR_RD;
        else                      state_next = fss_pkg::E_IDLE;
      end
      default: state_next = fss_pkg::E_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    we  = 1'b0;
    wa  = '0;
    wd  = key;
    case (state)
      fss_pkg::E_SORT_KEY:  ra0 = a[AW-1:0];
      fss_pkg::E_SORT_KEYW: ra0 = a_m1[AW-1:0];
      fss_pkg::E_SORT_CMP: begin
        ra0 = b_m2[AW-1:0];
        we  = 1'b1;
        wa  = b[AW-1:0];
        wd  = gt ? rd0 : key;
      end
      fss_pkg::E_SORT_PUT: begin
        we = 1'b1;
        wa = b[AW-1:0];
      end
      fss_pkg::E_PAIR_RD: begin
        ra0 = i[AW-1:0];
        ra1 = j[AW-1:0];
      end
      fss_pkg::E_LR_RD: begin
        ra0 = l[AW-1:0];
        ra1 = r[AW-1:0];
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fss_pkg::E_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == fss_pkg::E_LR_CMP) && (state_next == fss_pkg::E_IDLE);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      fss_pkg::E_IDLE: begin
        a <= CW'(1);
        i <= '0;
        j <= CW'(1);
      end
      fss_pkg::E_SORT_KEYW: begin
        key <= rd0;
        b   <= a;
      end
      fss_pkg::E_SORT_CMP: begin
        if (gt) b <= b_m1;
        else    a <= a_p1;
      end
      fss_pkg::E_SORT_PUT: a <= a_p1;
      fss_pkg::E_PAIR_WANT: begin
        want <= want_calc;
        pi   <= rd0.pos;
        pj   <= rd1.pos;
        l    <= j_p1;
        r    <= n - 1'b1;
      end
      fss_pkg::E_LR_CMP: begin
        l <= lo;
        r <= ro;
        if (hit) begin
          res <= '{found: 1'b1, p1: pi, p2: pj, p3: rd0.pos, p4: rd1.pos};
        end else if (!more) begin
          res <= '0;
          if (j_more) begin
            j <= j_p1;
          end else begin
            i <= i_p1;
            j <= i_p1 + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/four_sum_search.sv
// Sequence: after the last beat, an insertion sort orders the store, then
// each pair is set up and scanned by pointer steps (store read, then
// compare), and the result is reported.
// Throughput: 1 input beat per cycle while loading; one set at a time.
// Reset: synchronous, active high; clears counts, flags, target and FSMs.
// The item store is not cleared; only entries of the current set are read.
// ---------------------------------------------------------------------------
// four_sum_search: top level
// Loads values into the store, runs the sort/search engine on a last beat
// that brings the set to four or more items, and holds the result in an output register.
// ---------------------------------------------------------------------------
module four_sum_search #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fss_pkg::VAL_W-1:0]     value,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic                                 overflow,
  output logic [fss_pkg::POS_W-1:0]            pos_first,
  output logic [fss_pkg::POS_W-1:0]            pos_second,
  output logic [fss_pkg::POS_W-1:0]            pos_third,
  output logic [fss_pkg::POS_W-1:0]            pos_fourth,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic signed [fss_pkg::VAL_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);

  fss_pkg::top_state_t tstate, tstate_next;

  logic [CW-1:0] count, n_reg, n_next;
  logic [CW:0]   cnt_inc;
  logic          ovf, ovf_res, room, acc, start, few;
  logic signed [fss_pkg::VAL_W-1:0] target;
  fss_pkg::result_t res_hold, eng_res;
  logic eng_done, emit;

  logic [AW-1:0] e_ra0, e_ra1, e_wa, m_wa;
  logic e_we, m_we;
  fss_pkg::entry_t e_wd, m_wd, rd0, rd1;

  // input handshake and load bookkeeping
  assign in_stall  = tstate != fss_pkg::T_LOAD;
  assign cfg_ready = 1'b1;
  assign acc     = in_valid && !in_stall;
  assign room    = count < CW'(MAX_ITEMS);
  assign cnt_inc = {1'b0, count} + 1'b1;
  assign n_next  = room ? cnt_inc[CW-1:0] : count;
  assign few     = n_next < CW'(4);
  assign start   = acc && last && !few;
  assign emit    = (tstate == fss_pkg::T_EMIT) && (!out_valid || !out_stall);

  // store write select: loader while loading, engine otherwise
  always_comb begin
    if (tstate == fss_pkg::T_LOAD) begin
      m_we = acc && room;
      m_wa = count[AW-1:0];
      m_wd = '{val: value, pos: fss_pkg::POS_W'(cnt_inc)};
    end else begin
      m_we = e_we;
      m_wa = e_wa;
      m_wd = e_wd;
    end
  end

  // next state
  always_comb begin
    tstate_next = tstate;
    case (tstate)
      fss_pkg::T_LOAD:
        if (acc && last) tstate_next = few ? fss_pkg::T_EMIT : fss_pkg::T_RUN;
      fss_pkg::T_RUN:  if (eng_done) tstate_next = fss_pkg::T_EMIT;
      fss_pkg::T_EMIT: if (emit) tstate_next = fss_pkg::T_LOAD;
      default: tstate_next = fss_pkg::T_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate    <= fss_pkg::T_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      target    <= '0;
      out_valid <= 1'b0;
    end else begin
      tstate <= tstate_next;
      if (cfg_valid && cfg_ready) target <= cfg_data;
      if (acc) begin
        if (last) begin
          count <= '0;
          ovf   <= 1'b0;
        end else if (room) begin
          count <= cnt_inc[CW-1:0];
        end else begin
          ovf <= 1'b1;
        end
      end
      if (emit)                        out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc && last) begin
      n_reg   <= n_next;
      ovf_res <= ovf || !room;
      if (few) res_hold <= '0;
    end
    if (tstate == fss_pkg::T_RUN && eng_done) res_hold <= eng_res;
    if (emit) begin
      found      <= res_hold.found;
      overflow   <= ovf_res;
      pos_first  <= res_hold.p1;
      pos_second <= res_hold.p2;
      pos_third  <= res_hold.p3;
      pos_fourth <= res_hold.p4;
    end
  end

  fss_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem (
    .clk (clk),
    .we  (m_we),
    .wa  (m_wa),
    .wd  (m_wd),
    .ra0 (e_ra0),
    .ra1 (e_ra1),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  fss_engine #(.CW(CW), .AW(AW)) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .n      (n_reg),
    .target (target),
    .rd0    (rd0),
    .rd1    (rd1),
    .ra0    (e_ra0),
    .ra1    (e_ra1),
    .we     (e_we),
    .wa     (e_wa),
    .wd     (e_wd),
    .done   (eng_done),
    .res    (eng_res)
  );

  // fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count beyond store depth");

  // engine finishes only while the top level waits on it
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> tstate == fss_pkg::T_RUN)
    else $error("engine done outside run phase");

  // a miss reports all positions as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> pos_first == '0 && pos_second == '0 &&
                            pos_third == '0 && pos_fourth == '0)
    else $error("positions set on a miss");

  // a new result beat appears only after leaving the emit phase
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tstate) == fss_pkg::T_EMIT)
    else $error("result beat without emit");

endmodule
